/* design/pdck_pkg.sv */
// Shared constants, types and field positions of the pairwise dominance count kernel.
`timescale 1ns / 1ps
package pdck_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_DIMS   = 8;
    localparam int VALUE_BITS = 32;

    localparam int POINT_W   = $clog2(MAX_POINTS);
    localparam int DIM_W     = $clog2(MAX_DIMS);
    localparam int COUNT_W   = POINT_W + 1;
    localparam int DCNT_W    = DIM_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam int DIV_STEPS = COUNT_W + FRAC_BITS;
    localparam int DIV_CTR_W = $clog2(DIV_STEPS + 1);

    // Request tdata layout, lowest bits first.
    localparam int LD_PT_LSB  = 0;
    localparam int LD_DIM_LSB = LD_PT_LSB + POINT_W;
    localparam int VAL_LSB    = LD_DIM_LSB + DIM_W;
    localparam int ROW_LSB    = VAL_LSB + VALUE_BITS;
    localparam int COL_LSB    = ROW_LSB + POINT_W;
    localparam int S_FIELDS_W = COL_LSB + POINT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Result tdata layout, lowest bits first.
    localparam int M_FIELDS_W = COUNT_W + FRAC_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COUNT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT   = 2'd1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [MAX_DIMS-1:0][VALUE_BITS-1:0] pdck_row_t;

    typedef struct packed {
        logic load_we;
        logic query_start;
        logic rd_row;
        logic take_row;
        logic take_col;
        logic scan_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } pdck_cmd_t;

    typedef struct packed {
        logic bad;
        logic scan_done;
        logic div_done;
        logic out_free;
    } pdck_status_t;

endpackage

/* design/pdck_ctrl.sv */
// Controller state machine that sequences loads, queries, the scan and the division.
`timescale 1ns / 1ps
module pdck_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,
    input  pdck_pkg::pdck_status_t status,
    output pdck_pkg::pdck_cmd_t    cmd
);
    import pdck_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_ROW_I  = 3'd2;
    localparam logic [2:0] ST_ROW_J  = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_DIVIDE = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == OP_LOAD) begin
                    cmd.load_we = 1'b1;
                end else if (accept && s_tuser == OP_QUERY) begin
                    cmd.query_start = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.bad) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.rd_row = 1'b1;
                    state_next = ST_ROW_I;
                end
            end
            ST_ROW_I: begin
                cmd.take_row = 1'b1;
                state_next   = ST_ROW_J;
            end
            ST_ROW_J: begin
                cmd.take_col = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_RESULT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A result is only written into the output register when it has room.
    a_out_load_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register is occupied");

    // A query never starts the scan when one of its indexes is out of range.
    a_bad_skips_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && status.bad) |=> state_reg == ST_RESULT)
        else $error("bad-index query did not go straight to the result");

    // The divider is only started as the scan finishes.
    a_div_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (state_reg == ST_SCAN && status.scan_done))
        else $error("division started before the scan completed");

endmodule

/* design/pdck_datapath.sv */
// Datapath: sample store, threshold row, dominance scan, bit-serial divider and output register.
`timescale 1ns / 1ps
module pdck_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pdck_pkg::pdck_cmd_t               cmd,
    output pdck_pkg::pdck_status_t            status,
    input  logic [pdck_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              cfg_valid,
    input  logic [pdck_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pdck_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pdck_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);
    import pdck_pkg::*;

    logic [COUNT_W-1:0]    point_count_reg;
    logic [DCNT_W-1:0]     dim_count_reg;
    logic [COUNT_W-1:0]    n_eff;
    logic [DCNT_W-1:0]     nd_eff;

    logic [POINT_W-1:0]    ld_point;
    logic [DIM_W-1:0]      ld_dim;
    logic [VALUE_BITS-1:0] ld_value;

    logic [POINT_W-1:0]    row_reg;
    logic [POINT_W-1:0]    col_reg;

    logic                  rd_en;
    logic [POINT_W-1:0]    rd_addr;
    pdck_row_t             rd_data;
    pdck_row_t             thr_reg;
    pdck_row_t             thr_max;

    logic [COUNT_W-1:0]    scan_ctr_reg;
    logic                  scan_issue;
    logic                  pend_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  dominates;

    logic [DIV_CTR_W-1:0]  div_ctr_reg;
    logic [DIV_STEPS-1:0]  div_num_reg;
    logic [COUNT_W-1:0]    div_rem_reg;
    logic [COUNT_W:0]      rem_shift;
    logic                  rem_ge;

    logic                  out_valid_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [FRAC_W-1:0]     out_frac_reg;
    logic                  out_bad_reg;

    assign ld_point = s_tdata[LD_PT_LSB +: POINT_W];
    assign ld_dim   = s_tdata[LD_DIM_LSB +: DIM_W];
    assign ld_value = s_tdata[VAL_LSB +: VALUE_BITS];

    // Register clamping: zero acts as one, oversize acts as the maximum.
    always_comb begin
        if (point_count_reg == '0) begin
            n_eff = COUNT_W'(1);
        end else if (point_count_reg > COUNT_W'(MAX_POINTS)) begin
            n_eff = COUNT_W'(MAX_POINTS);
        end else begin
            n_eff = point_count_reg;
        end
        if (dim_count_reg == '0) begin
            nd_eff = DCNT_W'(1);
        end else if (dim_count_reg > DCNT_W'(MAX_DIMS)) begin
            nd_eff = DCNT_W'(MAX_DIMS);
        end else begin
            nd_eff = dim_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= COUNT_W'(1);
            dim_count_reg   <= DCNT_W'(1);
        end else if (cfg_valid) begin
            if (cfg_index == CFG_POINT_COUNT) begin
                point_count_reg <= cfg_data;
            end else if (cfg_index == CFG_DIM_COUNT) begin
                dim_count_reg <= cfg_data[DCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.query_start) begin
            row_reg <= s_tdata[ROW_LSB +: POINT_W];
            col_reg <= s_tdata[COL_LSB +: POINT_W];
        end
    end

    assign status.bad = ({1'b0, row_reg} >= n_eff) || ({1'b0, col_reg} >= n_eff);

    // One bank per coordinate; a row read returns all coordinates of a point.
    for (genvar b = 0; b < MAX_DIMS; b++) begin : g_bank
        logic [VALUE_BITS-1:0] bank_mem [MAX_POINTS];
        logic [VALUE_BITS-1:0] bank_q_reg;

        always_ff @(posedge aclk) begin
            if (cmd.load_we && ld_dim == DIM_W'(b)) begin
                bank_mem[ld_point] <= ld_value;
            end
            if (rd_en) begin
                bank_q_reg <= bank_mem[rd_addr];
            end
        end

        assign rd_data[b] = bank_q_reg;
    end

    assign scan_issue = cmd.scan_step && (scan_ctr_reg < n_eff);
    assign rd_en      = cmd.rd_row || cmd.take_row || cmd.take_col || scan_issue;

    always_comb begin
        if (cmd.rd_row) begin
            rd_addr = row_reg;
        end else if (cmd.take_row) begin
            rd_addr = col_reg;
        end else if (cmd.take_col) begin
            rd_addr = '0;
        end else begin
            rd_addr = scan_ctr_reg[POINT_W-1:0];
        end
    end

    always_comb begin
        dominates = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++) begin
            thr_max[k] = ($signed(rd_data[k]) > $signed(thr_reg[k])) ? rd_data[k] : thr_reg[k];
            if (DCNT_W'(k) < nd_eff && $signed(rd_data[k]) < $signed(thr_reg[k])) begin
                dominates = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_row) begin
            thr_reg <= rd_data;
        end else if (cmd.take_col) begin
            thr_reg <= thr_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            scan_ctr_reg <= '0;
            count_reg    <= '0;
        end else if (cmd.take_col) begin
            pend_reg     <= 1'b1;
            scan_ctr_reg <= COUNT_W'(1);
            count_reg    <= '0;
        end else if (cmd.scan_step) begin
            pend_reg <= scan_issue;
            if (scan_issue) begin
                scan_ctr_reg <= scan_ctr_reg + COUNT_W'(1);
            end
            if (pend_reg && dominates) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
    end

    assign status.scan_done = !pend_reg && (scan_ctr_reg >= n_eff);

    // Restoring division of count * 2^16 by the point count, one quotient bit a cycle.
    assign rem_shift = {div_rem_reg, div_num_reg[DIV_STEPS-1]};
    assign rem_ge    = rem_shift >= {1'b0, n_eff};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_ctr_reg <= '0;
        end else if (cmd.div_start) begin
            div_ctr_reg <= DIV_CTR_W'(DIV_STEPS);
        end else if (cmd.div_step && div_ctr_reg != '0) begin
            div_ctr_reg <= div_ctr_reg - DIV_CTR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_num_reg <= {count_reg, FRAC_BITS'(0)};
            div_rem_reg <= '0;
        end else if (cmd.div_step) begin
            div_num_reg <= {div_num_reg[DIV_STEPS-2:0], rem_ge};
            div_rem_reg <= rem_ge ? COUNT_W'(rem_shift - {1'b0, n_eff})
                                  : rem_shift[COUNT_W-1:0];
        end
    end

    assign status.div_done = (div_ctr_reg == '0);

    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_bad_reg   <= status.bad;
            out_count_reg <= status.bad ? '0 : count_reg;
            out_frac_reg  <= status.bad ? '0 : div_num_reg[FRAC_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_bad_reg;
    assign m_tdata  = M_TDATA_W'({out_frac_reg, out_count_reg});

    // The dominance count can never exceed the number of points scanned.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> count_reg <= n_eff)
        else $error("dominance count exceeds point count");

    // Starting the divider arms its full step count.
    a_div_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> div_ctr_reg == DIV_CTR_W'(DIV_STEPS))
        else $error("divider step counter not armed");

    // Scan reads never go past the configured point count.
    a_scan_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_issue |-> scan_ctr_reg < n_eff)
        else $error("scan read beyond point count");

endmodule

/* design/pairwise_dominance_count_kernel.sv */
// Top level of the pairwise dominance count kernel: stream ports, controller and datapath.
`timescale 1ns / 1ps
// A load request produces no result. A query with a valid pair passes the index check,
//   the two row reads, the row scan (one point read per cycle from the sample store) and
//   the 27-step divider; a query with a bad index goes from the check to the result.
// Throughput: one load per cycle while no query is in progress; a query holds off new
//   requests until its result is loaded into the output register.
// Reset (aresetn low, synchronous) clears the controller, the output valid and sets
//   point_count and dim_count to 1; the sample store keeps its contents and is undefined
//   until written.
module pairwise_dominance_count_kernel (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata fields from bit 0: point_index[10], dim_index[3], sample_value[32],
    // row_point[10], col_point[10], zero fill.
    input  logic [pdck_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: opcode (0 = load one coordinate, 1 = query a pair).
    input  logic                              s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata fields from bit 0: dominance_count[11], dominance_fraction[17], zero fill.
    output logic [pdck_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: bad_index.
    output logic                              m_tuser,
    // Configuration write channel: index 0 is point_count, index 1 is dim_count.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdck_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pdck_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pdck_pkg::*;

    pdck_cmd_t    cmd;
    pdck_status_t status;

    // Configuration registers are always writable; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    // The controller accepts a request only when idle. Loads go straight into the store;
    // a query walks through the index check and, if both indexes are in range, reads the
    // two rows into a per-coordinate threshold, scans every point and divides the count.
    pdck_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the store, the scan counter, the divider and the output
    // register, so a finished result can wait for m_tready while new loads are taken.
    pdck_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the pairwise dominance count kernel with a dominance scoreboard.
`timescale 1ns / 1ps
module tb;
    import pdck_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int TOTAL_ITEMS    = 580;
    localparam int IDLE_SETTLE    = 8;
    localparam int END_SETTLE     = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int MISMATCH_PRINT = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [VALUE_BITS-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [VALUE_BITS-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [VALUE_BITS-1:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [VALUE_BITS-1:0] VAL_NEG1 = 32'hffff_ffff;

    // One result: count, fraction and the bad-index flag.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [FRAC_W-1:0]  frac;
        logic               bad;
    } dominance_t;

    class tally_scoreboard;
        dominance_t  pending_tallies[$];
        int unsigned failures;
        int unsigned results_checked;

        function void note_query(dominance_t predicted);
            pending_tallies.push_back(predicted);
        endfunction

        function int unsigned pending();
            return pending_tallies.size();
        endfunction

        task report(string msg);
            failures++;
            if (failures <= MISMATCH_PRINT)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(dominance_t seen);
            dominance_t want;
            if (pending_tallies.size() == 0) begin
                report($sformatf("result with nothing pending (count %0d, bad %0d)",
                                 seen.count, seen.bad));
                return;
            end
            want = pending_tallies.pop_front();
            results_checked++;
            if (seen.count !== want.count)
                report($sformatf("dominance_count %0d, predicted %0d", seen.count, want.count));
            if (seen.frac !== want.frac)
                report($sformatf("dominance_fraction %0d, predicted %0d", seen.frac, want.frac));
            if (seen.bad !== want.bad)
                report($sformatf("bad_index %0d, predicted %0d", seen.bad, want.bad));
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    tally_scoreboard sb = new();

    // Mirror of the block: sample store and registers as the block sees them.
    logic [VALUE_BITS-1:0] sample_mem [0:MAX_POINTS-1][0:MAX_DIMS-1];
    logic [COUNT_W-1:0]    model_points = 1;
    logic [3:0]            model_dims   = 1;

    // Stimulus bookkeeping: which coordinates have been loaded and the current setting.
    bit stored_flag [0:MAX_POINTS-1][0:MAX_DIMS-1];
    int plan_points = 1;
    int plan_dims   = 1;
    int largest_points = 1;
    int settings_applied = 0;
    int sent_items = 0;
    bit no_stall = 1'b0;
    bit hold_req = 1'b0;
    int holds_done = 0;

    int loads_seen = 0;
    int queries_seen = 0;
    int bad_seen = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;

    pairwise_dominance_count_kernel u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Register values outside the legal range clamp to the nearest legal one.
    function automatic int eff_points(input logic [COUNT_W-1:0] value);
        int v;
        v = int'(value);
        if (v == 0) return 1;
        if (v > MAX_POINTS) return MAX_POINTS;
        return v;
    endfunction

    function automatic int eff_dims(input logic [3:0] value);
        int v;
        v = int'(value);
        if (v == 0) return 1;
        if (v > MAX_DIMS) return MAX_DIMS;
        return v;
    endfunction

    // Count the stored points that are at least as large as both queried points in every
    // coordinate in use, and the floored fraction of the point count they make up.
    function automatic dominance_t predict_dominance(input logic [POINT_W-1:0] row,
                                                     input logic [POINT_W-1:0] col);
        dominance_t  tally;
        int          n;
        int          nd;
        int unsigned hits;
        bit          above;
        longint      scaled;
        tally = '0;
        n     = eff_points(model_points);
        nd    = eff_dims(model_dims);
        hits  = 0;
        if (int'(row) >= n || int'(col) >= n) begin
            tally.bad = 1'b1;
            return tally;
        end
        for (int l = 0; l < n; l++) begin
            above = 1'b1;
            for (int k = 0; k < nd; k++) begin
                if ($signed(sample_mem[l][k]) < $signed(sample_mem[row][k]) ||
                    $signed(sample_mem[l][k]) < $signed(sample_mem[col][k]))
                    above = 1'b0;
            end
            if (above) hits++;
        end
        scaled      = longint'(hits) << FRAC_BITS;
        tally.count = COUNT_W'(hits);
        tally.frac  = FRAC_W'(scaled / n);
        return tally;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_request(input logic [POINT_W-1:0] point,
                                                          input logic [DIM_W-1:0] dim,
                                                          input logic [VALUE_BITS-1:0] value,
                                                          input logic [POINT_W-1:0] row,
                                                          input logic [POINT_W-1:0] col);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[LD_PT_LSB +: POINT_W]   = point;
        word[LD_DIM_LSB +: DIM_W]    = dim;
        word[VAL_LSB +: VALUE_BITS]  = value;
        word[ROW_LSB +: POINT_W]     = row;
        word[COL_LSB +: POINT_W]     = col;
        return word;
    endfunction

    // Mostly short gaps, some medium ones and a rare long one; none in a steady phase.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_stall || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Small values give ties and frequent dominance; extremes and full words fill the rest.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        int r;
        int near;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            near = $urandom_range(0, 6);
            return near - 3;
        end
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_ZERO;
                default: return VAL_NEG1;
            endcase
        end
        return $urandom;
    endfunction

    // Upper bits of the dim_count write are random; only the low four bits matter.
    function automatic logic [CFG_DATA_W-1:0] dim_word(input logic [3:0] dims);
        logic [CFG_DATA_W-1:0] word;
        word      = CFG_DATA_W'($urandom_range(0, 2047));
        word[3:0] = dims;
        return word;
    endfunction

    task automatic send_request(input logic op, input logic [S_TDATA_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic send_load(input logic [POINT_W-1:0] point, input logic [DIM_W-1:0] dim,
                             input logic [VALUE_BITS-1:0] value);
        send_request(OP_LOAD, pack_request(point, dim, value,
                                           POINT_W'($urandom_range(0, 1023)),
                                           POINT_W'($urandom_range(0, 1023))));
        stored_flag[point][dim] = 1'b1;
    endtask

    task automatic send_query(input logic [POINT_W-1:0] row, input logic [POINT_W-1:0] col);
        send_request(OP_QUERY, pack_request(POINT_W'($urandom_range(0, 1023)),
                                            DIM_W'($urandom_range(0, 7)),
                                            $urandom, row, col));
    endtask

    // Drops the request valid and waits until every result is back and the block is quiet.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write of a group.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] points_word,
                                  input logic [CFG_DATA_W-1:0] dims_word);
        wait_idle();
        if ($urandom_range(0, 2) == 0)
            write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                           CFG_DATA_W'($urandom_range(0, 2047)));
        write_register(CFG_POINT_COUNT, points_word);
        write_register(CFG_DIM_COUNT, dims_word);
        cfg_valid <= 1'b0;
        plan_points = eff_points(points_word);
        plan_dims   = eff_dims(dims_word[3:0]);
        if (plan_points > largest_points) largest_points = plan_points;
        settings_applied++;
    endtask

    // Every coordinate that a query can read must be loaded before the first query.
    task automatic fill_store();
        for (int p = 0; p < plan_points; p++)
            for (int d = 0; d < plan_dims; d++)
                if (!stored_flag[p][d]) send_load(POINT_W'(p), DIM_W'(d), pick_value());
    endtask

    task automatic run_mix(input int count, input int query_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < query_pct) begin
                if (r < 85)
                    send_query(POINT_W'($urandom_range(0, plan_points - 1)),
                               POINT_W'($urandom_range(0, plan_points - 1)));
                else if (r < 93)
                    send_query(POINT_W'($urandom_range(0, 1023)),
                               POINT_W'($urandom_range(0, plan_points - 1)));
                else
                    send_query(POINT_W'($urandom_range(0, 1023)),
                               POINT_W'($urandom_range(0, 1023)));
            end else begin
                if (r < 60)
                    send_load(POINT_W'($urandom_range(0, plan_points - 1)),
                              DIM_W'($urandom_range(0, 7)), pick_value());
                else
                    send_load(POINT_W'($urandom_range(0, 1023)),
                              DIM_W'($urandom_range(0, 7)), pick_value());
            end
        end
    endtask

    // Result receiver: random ready pattern, plus one long hold-off on request.
    initial begin
        int run;
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 8);
                m_tready <= 1'b1;
                repeat (run) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Monitor: checks results, tracks register writes and predicts each accepted query.
    always @(posedge aclk) begin : monitor
        dominance_t seen;
        dominance_t predicted;
        logic [POINT_W-1:0] row;
        logic [POINT_W-1:0] col;
        if (!aresetn) begin
            model_points = 1;
            model_dims   = 1;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.count = m_tdata[COUNT_W-1:0];
                seen.frac  = m_tdata[COUNT_W +: FRAC_W];
                seen.bad   = m_tuser;
                sb.check_result(seen);
            end
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                case (cfg_index)
                    CFG_POINT_COUNT: model_points = cfg_data;
                    CFG_DIM_COUNT:   model_dims   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_LOAD) begin
                    sample_mem[s_tdata[LD_PT_LSB +: POINT_W]][s_tdata[LD_DIM_LSB +: DIM_W]] =
                        s_tdata[VAL_LSB +: VALUE_BITS];
                    loads_seen++;
                end else begin
                    row = s_tdata[ROW_LSB +: POINT_W];
                    col = s_tdata[COL_LSB +: POINT_W];
                    predicted = predict_dominance(row, col);
                    if (predicted.bad) bad_seen++;
                    queries_seen++;
                    sb.note_query(predicted);
                end
            end
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired: %0d cycles without a transfer, %0d results pending",
                     quiet_cycles, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int phase;
        int n_items;
        int query_pct;
        int r;
        logic [CFG_DATA_W-1:0] points_word;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setting is one point with one coordinate: the only point dominates itself
        // (full fraction), and any other index is a bad index.
        send_load(0, 0, VAL_MIN);
        send_query(0, 0);
        send_query(1, 0);
        send_query(0, 1023);
        send_query(1023, 1023);

        // Four points in two coordinates built from the value extremes; the pair (1, 2)
        // has no dominating point, point 0 is dominated by all.
        apply_settings(11'd4, dim_word(4'd2));
        send_load(0, 0, VAL_MIN);
        send_load(0, 1, VAL_MIN);
        send_load(1, 0, VAL_MAX);
        send_load(1, 1, VAL_MIN);
        send_load(2, 0, VAL_MIN);
        send_load(2, 1, VAL_MAX);
        send_load(3, 0, VAL_ZERO);
        send_load(3, 1, VAL_NEG1);
        send_query(0, 0);
        send_query(1, 2);
        send_query(1, 1);
        send_query(3, 3);
        send_query(3, 0);
        send_query(4, 0);
        send_query(2, 5);

        // Random phases: the first few pin register corner values, one applies back
        // pressure, the rest pick small settings with a few larger ones.
        phase = 0;
        while (sent_items < TOTAL_ITEMS) begin
            no_stall = ($urandom_range(0, 4) == 0);
            case (phase)
                0: apply_settings(11'd0, dim_word(4'd0));
                1: apply_settings(11'd12, dim_word(4'd15));
                2: apply_settings(11'd3, dim_word(4'd8));
                3: apply_settings(11'd1, dim_word(4'd1));
                4: begin
                    no_stall = 1'b0;
                    apply_settings(11'd6, dim_word(4'd3));
                end
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 75) points_word = CFG_DATA_W'($urandom_range(2, 16));
                    else        points_word = CFG_DATA_W'($urandom_range(17, 32));
                    apply_settings(points_word, dim_word(4'($urandom_range(1, 8))));
                end
            endcase
            fill_store();
            query_pct = 45;
            if (phase == 4) begin
                // Receiver stalls while queries keep coming, so the block backs up.
                query_pct = 90;
                n_items   = 40;
                hold_req  = 1'b1;
            end else begin
                n_items = $urandom_range(15, 50);
                if (sent_items + n_items > TOTAL_ITEMS)
                    n_items = (sent_items < TOTAL_ITEMS) ? TOTAL_ITEMS - sent_items : 0;
            end
            run_mix(n_items, query_pct);
            phase++;
        end

        wait_idle();
        repeat (END_SETTLE) @(posedge aclk);

        $display("Run covered %0d coordinate loads and %0d pair queries (%0d with a bad index).",
                 loads_seen, queries_seen, bad_seen);
        $display("%0d register writes over %0d settings, up to %0d points; %0d results checked.",
                 cfg_writes, settings_applied, largest_points, sb.results_checked);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
